FILE: sv/i4dp_pkg.sv
package i4dp_pkg;

   localparam int NIB_BITS         = 4;
   localparam int DIFF_BITS        = 5;
   localparam int SCALE_BITS       = 16;
   localparam int FRAC_BITS        = 12;
   localparam int RES_BITS         = 32;
   // nibbles past bit 63 of the weight word read as zero
   localparam int WORD_NIBBLES_MAX = 16;

   localparam logic [NIB_BITS-1:0] ZERO_POINT_RESET = 4'd8;

   localparam logic signed [RES_BITS-1:0] RES_MAX = 32'sh7fff_ffff;
   localparam logic signed [RES_BITS-1:0] RES_MIN = 32'sh8000_0000;

   // accumulator magnitude at or above 2^47 saturates the scaled result when the row scale is nonzero
   localparam logic signed [64:0] BIG_LIMIT = 65'sd140737488355328;

   typedef struct packed {
      logic                          valid;
      logic                          row_end;
      logic signed [SCALE_BITS-1:0]  row_scale;
   } item_tag_type;

   typedef struct packed {
      logic                          valid;
      logic                          overflow;
      logic signed [SCALE_BITS-1:0]  row_scale;
   } row_tag_type;

endpackage

FILE: sv/i4dp_req_if.sv
interface i4dp_req_if #(
   parameter int NIBBLES_PER_ITEM = 8,
   parameter int ACT_BITS         = 16
);
   logic                                         valid;
   logic                                         ready;
   logic [i4dp_pkg::NIB_BITS*NIBBLES_PER_ITEM-1:0] weight_word;
   // act_k at bits (k+1)*ACT_BITS-1 .. k*ACT_BITS, each signed
   logic [NIBBLES_PER_ITEM*ACT_BITS-1:0]          act;
   logic signed [i4dp_pkg::SCALE_BITS-1:0]        row_scale;
   logic                                         row_end;

   modport source (output valid, weight_word, act, row_scale, row_end, input ready);
   modport sink   (input valid, weight_word, act, row_scale, row_end, output ready);
endinterface

FILE: sv/i4dp_rsp_if.sv
interface i4dp_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [i4dp_pkg::RES_BITS-1:0]  row_result;
   logic                                  saturated;

   modport source (output valid, row_result, saturated, input ready);
   modport sink   (input valid, row_result, saturated, output ready);
endinterface

FILE: sv/i4dp_csr_if.sv
interface i4dp_csr_if;
   logic                               valid;
   logic                               ready;
   logic [i4dp_pkg::NIB_BITS-1:0]      weight_zero_point;

   modport source (output valid, weight_zero_point, input ready);
   modport sink   (input valid, weight_zero_point, output ready);
endinterface

FILE: sv/int4_dot_product_row_scale_top.sv
// Row ends pass lane, merge, row-hold, scale and rsp registers. Throughput:
// one item per cycle unless rsp stalls; the lane multipliers, merge adder and
// accumulator each take one item a cycle, the accumulate loop is a single add.
// Only row-end items produce a transfer on rsp; other items leave no result.
// Reset (synchronous): accumulator, overflow flag and all valids clear,
// zero point returns to 8.
module int4_dot_product_row_scale_top #(
   parameter int NIBBLES_PER_ITEM = 8,
   parameter int ACT_BITS         = 16,
   parameter int ACC_BITS         = 48
) (
   input  logic           clock,
   input  logic           reset,
   i4dp_req_if.sink       req_chan,
   i4dp_rsp_if.source     rsp_chan,
   i4dp_csr_if.sink       csr_chan
);
   import i4dp_pkg::*;

   localparam int PROD_BITS = ACT_BITS + DIFF_BITS;
   localparam int SUM_BITS  = PROD_BITS + $clog2(NIBBLES_PER_ITEM);

   // ---------------------------------------------------------------------
   // Configuration: always ready, one register
   // ---------------------------------------------------------------------
   logic [NIB_BITS-1:0] zero_point_ff;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_point_ff <= ZERO_POINT_RESET;
      end else if (csr_chan.valid) begin
         zero_point_ff <= csr_chan.weight_zero_point;
      end
   end

   // ---------------------------------------------------------------------
   // Pipeline control. Each stage loads when empty or when its content
   // moves on. Stage 1 = lane products, stage 2 = merged item sum,
   // stage 3 = held row total, stage 4 = scale product, then rsp register.
   // ---------------------------------------------------------------------
   item_tag_type tag1_ff;
   item_tag_type tag2_ff;
   row_tag_type  row_tag;
   logic signed [ACC_BITS-1:0] row_acc;
   logic         load1;
   logic         load2;
   logic         take;      // stage 2 item consumed by the accumulator
   logic         load4;

   assign load2          = !tag2_ff.valid || take;
   assign load1          = !tag1_ff.valid || load2;
   assign req_chan.ready = load1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff.valid <= 1'b0;
         tag2_ff.valid <= 1'b0;
      end else begin
         if (load1) begin
            tag1_ff.valid <= req_chan.valid;
         end
         if (load2) begin
            tag2_ff.valid <= tag1_ff.valid;
         end
      end
   end

   // tag payload: row marker and scale ride alongside the lanes
   always_ff @(posedge clock) begin
      if (load1) begin
         tag1_ff.row_end   <= req_chan.row_end;
         tag1_ff.row_scale <= req_chan.row_scale;
      end
      if (load2) begin
         tag2_ff.row_end   <= tag1_ff.row_end;
         tag2_ff.row_scale <= tag1_ff.row_scale;
      end
   end

   // ---------------------------------------------------------------------
   // Lanes: one nibble x activation product each
   // ---------------------------------------------------------------------
   logic signed [PROD_BITS-1:0] products [NIBBLES_PER_ITEM];
   logic [NIB_BITS-1:0]         nibbles  [NIBBLES_PER_ITEM];

   for (genvar k = 0; k < NIBBLES_PER_ITEM; k++) begin : g_lane
      if (k < WORD_NIBBLES_MAX) begin : g_nib
         assign nibbles[k] = req_chan.weight_word[k*NIB_BITS +: NIB_BITS];
      end else begin : g_zero
         assign nibbles[k] = '0;
      end

      i4dp_lane #(
         .ACT_BITS (ACT_BITS)
      ) u_lane (
         .clock      (clock),
         .load       (load1),
         .zero_point (zero_point_ff),
         .nibble     (nibbles[k]),
         .act        ($signed(req_chan.act[k*ACT_BITS +: ACT_BITS])),
         .product_ff (products[k])
      );
   end

   // ---------------------------------------------------------------------
   // Merge: exact item sum of the lane products
   // ---------------------------------------------------------------------
   logic signed [SUM_BITS-1:0] item_sum;

   i4dp_merge #(
      .NIBBLES_PER_ITEM (NIBBLES_PER_ITEM),
      .ACT_BITS         (ACT_BITS)
   ) u_merge (
      .clock    (clock),
      .load     (load2),
      .products (products),
      .sum_ff   (item_sum)
   );

   // ---------------------------------------------------------------------
   // Saturating row accumulator; row end hands the total to the scaler
   // ---------------------------------------------------------------------
   i4dp_acc #(
      .NIBBLES_PER_ITEM (NIBBLES_PER_ITEM),
      .ACT_BITS         (ACT_BITS),
      .ACC_BITS         (ACC_BITS)
   ) u_acc (
      .clock      (clock),
      .reset      (reset),
      .tag        (tag2_ff),
      .sum        (item_sum),
      .next_load  (load4),
      .take       (take),
      .row_ff     (row_tag),
      .row_acc_ff (row_acc)
   );

   // ---------------------------------------------------------------------
   // Row scale: multiply, floor shift by 12, clamp to 32 bits
   // ---------------------------------------------------------------------
   i4dp_scale #(
      .ACC_BITS (ACC_BITS)
   ) u_scale (
      .clock         (clock),
      .reset         (reset),
      .row           (row_tag),
      .row_acc       (row_acc),
      .rsp_ready     (rsp_chan.ready),
      .load          (load4),
      .rsp_valid_ff  (rsp_chan.valid),
      .row_result_ff (rsp_chan.row_result),
      .saturated_ff  (rsp_chan.saturated)
   );

   // ---------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------
   // input only stalls when a result waits on rsp
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (rsp_chan.valid && !rsp_chan.ready))
      else $error("input stalled without rsp back-pressure");

   // items that are not row ends never wait at the accumulator
   a_mid_row_flows: assert property (@(posedge clock) disable iff (reset)
      (tag2_ff.valid && !tag2_ff.row_end) |-> take)
      else $error("mid-row item held at accumulator");

   // a held row total stays put while the scaler is blocked
   a_row_hold: assert property (@(posedge clock) disable iff (reset)
      (row_tag.valid && !load4) |=> (row_tag.valid && $stable(row_acc)))
      else $error("row total changed while held");

endmodule

FILE: sv/i4dp_lane.sv
module i4dp_lane #(
   parameter int ACT_BITS = 16
) (
   input  logic                                          clock,
   input  logic                                          load,
   input  logic [i4dp_pkg::NIB_BITS-1:0]                 zero_point,
   input  logic [i4dp_pkg::NIB_BITS-1:0]                 nibble,
   input  logic signed [ACT_BITS-1:0]                    act,
   output logic signed [ACT_BITS+i4dp_pkg::DIFF_BITS-1:0] product_ff
);
   import i4dp_pkg::*;

   localparam int PROD_BITS = ACT_BITS + DIFF_BITS;

   logic signed [DIFF_BITS-1:0] diff;
   logic signed [PROD_BITS-1:0] product_in;

   // range -15..15
   assign diff       = $signed({1'b0, nibble}) - $signed({1'b0, zero_point});
   assign product_in = PROD_BITS'(diff) * PROD_BITS'(act);

   always_ff @(posedge clock) begin
      if (load) begin
         product_ff <= product_in;
      end
   end

endmodule

FILE: sv/i4dp_merge.sv
module i4dp_merge #(
   parameter int NIBBLES_PER_ITEM = 8,
   parameter int ACT_BITS         = 16
) (
   input  logic clock,
   input  logic load,
   input  logic signed [ACT_BITS+i4dp_pkg::DIFF_BITS-1:0] products [NIBBLES_PER_ITEM],
   output logic signed [ACT_BITS+i4dp_pkg::DIFF_BITS+$clog2(NIBBLES_PER_ITEM)-1:0] sum_ff
);
   import i4dp_pkg::*;

   localparam int SUM_BITS = ACT_BITS + DIFF_BITS + $clog2(NIBBLES_PER_ITEM);

   logic signed [SUM_BITS-1:0] sum_in;

   always_comb begin
      sum_in = '0;
      for (int k = 0; k < NIBBLES_PER_ITEM; k++) begin
         sum_in = sum_in + SUM_BITS'(products[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sum_ff <= sum_in;
      end
   end

endmodule

FILE: sv/i4dp_acc.sv
module i4dp_acc #(
   parameter int NIBBLES_PER_ITEM = 8,
   parameter int ACT_BITS         = 16,
   parameter int ACC_BITS         = 48
) (
   input  logic                          clock,
   input  logic                          reset,
   input  i4dp_pkg::item_tag_type        tag,
   input  logic signed [ACT_BITS+i4dp_pkg::DIFF_BITS+$clog2(NIBBLES_PER_ITEM)-1:0] sum,
   input  logic                          next_load,
   output logic                          take,
   output i4dp_pkg::row_tag_type         row_ff,
   output logic signed [ACC_BITS-1:0]    row_acc_ff
);
   import i4dp_pkg::*;

   localparam int SUM_BITS  = ACT_BITS + DIFF_BITS + $clog2(NIBBLES_PER_ITEM);
   localparam int WIDE_BITS = ((ACC_BITS > SUM_BITS) ? ACC_BITS : SUM_BITS) + 1;
   localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
   localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

   logic signed [ACC_BITS-1:0]  acc_ff;
   logic                        overflow_ff;
   logic signed [WIDE_BITS-1:0] wide;
   logic                        over;
   logic                        under;
   logic signed [ACC_BITS-1:0]  acc_in;
   logic                        load;

   assign wide  = WIDE_BITS'(acc_ff) + WIDE_BITS'(sum);
   assign over  = wide > WIDE_BITS'(ACC_MAX);
   assign under = wide < WIDE_BITS'(ACC_MIN);

   always_comb begin
      if (over) begin
         acc_in = ACC_MAX;
      end else if (under) begin
         acc_in = ACC_MIN;
      end else begin
         acc_in = ACC_BITS'(wide);
      end
   end

   // row holding register frees when the scaler takes it
   assign load = !row_ff.valid || next_load;
   // ordinary items never wait; a row end waits for the holding register
   assign take = tag.valid && (!tag.row_end || load);

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         overflow_ff  <= 1'b0;
         row_ff.valid <= 1'b0;
      end else begin
         if (take) begin
            if (tag.row_end) begin
               acc_ff      <= '0;
               overflow_ff <= 1'b0;
            end else begin
               acc_ff      <= acc_in;
               overflow_ff <= overflow_ff | over | under;
            end
         end
         if (load) begin
            row_ff.valid <= tag.valid && tag.row_end;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take && tag.row_end) begin
         row_acc_ff         <= acc_in;
         row_ff.overflow    <= overflow_ff | over | under;
         row_ff.row_scale   <= tag.row_scale;
      end
   end

endmodule

FILE: sv/i4dp_scale.sv
module i4dp_scale #(
   parameter int ACC_BITS = 48
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  i4dp_pkg::row_tag_type                  row,
   input  logic signed [ACC_BITS-1:0]             row_acc,
   input  logic                                   rsp_ready,
   output logic                                   load,
   output logic                                   rsp_valid_ff,
   output logic signed [i4dp_pkg::RES_BITS-1:0]   row_result_ff,
   output logic                                   saturated_ff
);
   import i4dp_pkg::*;

   localparam int PROD_BITS = ACC_BITS + SCALE_BITS;

   logic                        mult_valid_ff;
   logic signed [PROD_BITS-1:0] prod_ff;
   logic                        big_ff;
   logic                        neg_ff;
   logic                        overflow_ff;

   logic signed [64:0]          acc_ext;
   logic                        big_in;
   logic                        out_load;
   logic signed [PROD_BITS-1:0] quot;
   logic signed [RES_BITS-1:0]  result_in;
   logic                        sat_in;

   assign out_load = !rsp_valid_ff || rsp_ready;
   assign load     = !mult_valid_ff || out_load;

   assign acc_ext = 65'(row_acc);
   assign big_in  = (acc_ext >= BIG_LIMIT || acc_ext <= -BIG_LIMIT) && (row.row_scale != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         mult_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (load) begin
            mult_valid_ff <= row.valid;
         end
         if (out_load) begin
            rsp_valid_ff <= mult_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff     <= PROD_BITS'(row_acc) * PROD_BITS'(row.row_scale);
         big_ff      <= big_in;
         neg_ff      <= row_acc[ACC_BITS-1] ^ row.row_scale[SCALE_BITS-1];
         overflow_ff <= row.overflow;
      end
   end

   // arithmetic shift gives the floor
   assign quot = prod_ff >>> FRAC_BITS;

   always_comb begin
      if (big_ff) begin
         result_in = neg_ff ? RES_MIN : RES_MAX;
         sat_in    = 1'b1;
      end else if (quot > PROD_BITS'(RES_MAX)) begin
         result_in = RES_MAX;
         sat_in    = 1'b1;
      end else if (quot < PROD_BITS'(RES_MIN)) begin
         result_in = RES_MIN;
         sat_in    = 1'b1;
      end else begin
         result_in = quot[RES_BITS-1:0];
         sat_in    = overflow_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load && mult_valid_ff) begin
         row_result_ff <= result_in;
         saturated_ff  <= sat_in | overflow_ff;
      end
   end

endmodule
